FILE: rtl/hbd_pkg.sv
// package for the hdlc byte deframer with crc-16 check
// holds the transaction payload structs, framing constants and the crc byte fold
// no dependencies
package hbd_pkg;

  localparam int unsigned IdxW = 6;

  localparam logic       ActByte    = 1'b0;
  localparam logic       ActRestart = 1'b1;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic            byte_stored;
    logic [7:0]      byte_value;
    logic [IdxW-1:0] byte_index;
    logic            frame_done;
    logic            frame_good;
  } out_t;

  // msb-first crc-16 update over one byte, bit steps unrolled
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/hdlc_byte_deframer_crc_check.sv
// each result is registered into the result register, or into the skid entry behind it
// throughput: one byte per cycle while the skid entry is empty; the crc fold and flag decode sit in one stage
// a two-entry output buffer (result register plus skid) keeps input flowing
// into a downstream stall until the skid entry fills; input ready drops only while the skid entry is full
// reset (async, active low) clears frame state, crc, byte history and both output entries
//
// top level of the hdlc byte deframer with crc-16 check
// depends on hbd_pkg
module hdlc_byte_deframer_crc_check
  import hbd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // count holds 0 .. MAX_BYTES-1; one extra bit for the post-increment compare
  localparam int unsigned CntW  = $clog2(MAX_BYTES);
  localparam int unsigned WideW = CntW + IdxW;

  // frame state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            open_q, open_d;
  logic            esc_q, esc_d;
  logic            over_q, over_d;
  logic            good_q, good_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      last_q, last_d;
  logic [7:0]      second_q, second_d;

  // output buffer
  logic out_valid_q;
  out_t out_q;
  logic skid_valid_q;
  out_t skid_q;

  logic accept;
  logic drain;
  out_t res;

  logic [CntW:0]    cnt_inc;
  logic [WideW-1:0] cnt_wide;
  logic [7:0]       data_val;

  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign drain       = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_inc  = {1'b0, cnt_q} + (CntW+1)'(1);
  assign cnt_wide = WideW'(cnt_q);
  // unescape with the pending escape, if any
  assign data_val = esc_q ? (in_data_i.rx_byte ^ EscXor) : in_data_i.rx_byte;

  // one-pass deframe step for the byte at the input
  always_comb begin
    cnt_d    = cnt_q;
    open_d   = open_q;
    esc_d    = esc_q;
    over_d   = over_q;
    good_d   = good_q;
    crc_d    = crc_q;
    last_d   = last_q;
    second_d = second_q;
    res      = '0;

    if (in_data_i.action == ActRestart) begin
      // restart clears everything
      cnt_d    = '0;
      open_d   = 1'b0;
      esc_d    = 1'b0;
      over_d   = 1'b0;
      good_d   = 1'b0;
      crc_d    = '0;
      last_d   = '0;
      second_d = '0;
    end else if (!over_q) begin
      if (in_data_i.rx_byte == FlagByte) begin
        if (cnt_q == '0) begin
          open_d = 1'b1;
        end else begin
          // closing flag: crc trails by two bytes, those two carry the crc low first
          over_d         = 1'b1;
          res.frame_done = 1'b1;
          good_d         = (cnt_q >= CntW'(2)) && (crc_q == {last_q, second_q});
        end
      end else if (in_data_i.rx_byte == EscByte) begin
        esc_d = 1'b1;
      end else if (open_q) begin
        esc_d           = 1'b0;
        res.byte_stored = 1'b1;
        res.byte_value  = data_val;
        res.byte_index  = cnt_wide[IdxW-1:0];
        if (cnt_q >= CntW'(2)) begin
          crc_d = crc_fold(crc_q, second_q);
        end
        second_d = last_q;
        last_d   = data_val;
        cnt_d    = cnt_inc[CntW-1:0];
        // buffer full: wrap and restart the frame body, frame stays open
        if (cnt_inc == (CntW+1)'(MAX_BYTES)) begin
          cnt_d    = '0;
          esc_d    = 1'b0;
          crc_d    = '0;
          last_d   = '0;
          second_d = '0;
        end
      end
    end
    res.frame_good = good_d;
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      open_q   <= 1'b0;
      esc_q    <= 1'b0;
      over_q   <= 1'b0;
      good_q   <= 1'b0;
      crc_q    <= '0;
      last_q   <= '0;
      second_q <= '0;
    end else if (accept) begin
      cnt_q    <= cnt_d;
      open_q   <= open_d;
      esc_q    <= esc_d;
      over_q   <= over_d;
      good_q   <= good_d;
      crc_q    <= crc_d;
      last_q   <= last_d;
      second_q <= second_d;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      skid_valid_q <= 1'b0;
      skid_q       <= '0;
    end else begin
      if (drain) begin
        if (skid_valid_q) begin
          // no accept possible here, ready is low while skid is full
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept;
          if (accept) begin
            out_q <= res;
          end
        end
      end else if (accept) begin
        if (out_valid_q) begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end else begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a transaction with no result in front");

  // a closed frame must have been opened by a flag
  a_over_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> open_q)
    else $error("frame closed without being opened");

  // bytes are only counted inside an open frame
  a_count_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> open_q)
    else $error("byte count nonzero outside a frame");

  // restart leaves the receiver empty
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.action == ActRestart) |=>
      (cnt_q == '0) && !open_q && !over_q && !good_q && (crc_q == '0))
    else $error("restart left frame state behind");

endmodule

FILE: verif/hbd_checker.sv
// result checker for the hdlc byte deframer with crc-16 check
// watches both channels, predicts every result and compares it field by field
// depends on hbd_pkg
module hbd_checker
  import hbd_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned live_items_o,
  output int unsigned frames_o,
  output int unsigned good_frames_o
);

  // predicted deframer state
  int unsigned fill;
  logic        open_q;
  logic        esc_q;
  logic        over_q;
  logic        good_q;
  logic [15:0] crc_q;
  logic [7:0]  last_q;
  logic [7:0]  prev_q;

  out_t predicted_results[$];

  // bitwise msb-first crc-16 step
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = r << 1;
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  task automatic clear_frame();
    fill   = 0;
    esc_q  = 1'b0;
    crc_q  = '0;
    last_q = '0;
    prev_q = '0;
  endtask

  task automatic deframe_item(input in_t item, output out_t res);
    logic [7:0] v;
    res = '0;
    if (item.action == ActRestart) begin
      clear_frame();
      open_q = 1'b0;
      over_q = 1'b0;
      good_q = 1'b0;
    end else if (!over_q) begin
      if (item.rx_byte == FlagByte) begin
        if (fill == 0) begin
          open_q = 1'b1;
        end else begin
          over_q = 1'b1;
          res.frame_done = 1'b1;
          good_q = (fill >= 2) && (crc_q == {last_q, prev_q});
          frames_o++;
          if (good_q) begin
            good_frames_o++;
          end
        end
      end else if (item.rx_byte == EscByte) begin
        esc_q = 1'b1;
      end else if (open_q) begin
        v = esc_q ? (item.rx_byte ^ EscXor) : item.rx_byte;
        esc_q = 1'b0;
        res.byte_stored = 1'b1;
        res.byte_value  = v;
        res.byte_index  = IdxW'(fill);
        if (fill >= 2) begin
          crc_q = crc_step(crc_q, prev_q);
        end
        prev_q = last_q;
        last_q = v;
        fill++;
        if (fill >= MAX_BYTES) begin
          clear_frame();
        end
      end
    end
    res.frame_good = good_q;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t res;
    out_t want;
    if (!rst_ni) begin
      clear_frame();
      open_q = 1'b0;
      over_q = 1'b0;
      good_q = 1'b0;
      predicted_results.delete();
      err_count_o   = 0;
      pending_o     = 0;
      live_items_o  = 0;
      frames_o      = 0;
      good_frames_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.action == ActRestart || !over_q) begin
          live_items_o++;
        end
        deframe_item(in_data_i, res);
        predicted_results.push_back(res);
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %0h", $time, out_data_i);
          err_count_o++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_stored", 32'(want.byte_stored), 32'(out_data_i.byte_stored));
          check_field("byte_value", 32'(want.byte_value), 32'(out_data_i.byte_value));
          check_field("byte_index", 32'(want.byte_index), 32'(out_data_i.byte_index));
          check_field("frame_done", 32'(want.frame_done), 32'(out_data_i.frame_done));
          check_field("frame_good", 32'(want.frame_good), 32'(out_data_i.frame_good));
        end
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// top of the deframer testbench: clock, reset, stimulus and verdict
// drives directed and random byte streams, checking is done in hbd_checker
// depends on hbd_pkg, hdlc_byte_deframer_crc_check and hbd_checker
module testbench;
  import hbd_pkg::*;

  localparam int unsigned MaxBytes      = 64;
  localparam int unsigned ItemsPerPhase = 500;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 82;
  int unsigned sent          = 0;

  int unsigned errs;
  int unsigned pending;
  int unsigned live_items;
  int unsigned frames;
  int unsigned good_frames;

  hdlc_byte_deframer_crc_check #(
    .MAX_BYTES(MaxBytes)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  hbd_checker #(
    .MAX_BYTES(MaxBytes)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .err_count_o  (errs),
    .pending_o    (pending),
    .live_items_o (live_items),
    .frames_o     (frames),
    .good_frames_o(good_frames)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or drops results
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one transaction on the input channel, with a random idle gap in front
  // valid is only lowered when a gap is taken, so back-to-back items keep it high
  task automatic push_item(input logic act, input logic [7:0] data);
    in_t         item;
    int unsigned gap;
    item.action  = act;
    item.rx_byte = data;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // restart, opening flag, optional filler to force an overrun, then a payload
  // with its crc appended low byte first, escaped where needed, and a closing flag
  task automatic send_frame(input int unsigned pad, input int unsigned len,
                            input bit corrupt, input bit truncate);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int unsigned k;
    crc = '0;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      body.push_back(b);
      for (int j = 7; j >= 0; j--) begin
        crc = {crc[14:0], 1'b0} ^ ((crc[15] ^ b[j]) ? CrcPoly : 16'h0000);
      end
    end
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    // single bit error somewhere in payload or crc
    if (corrupt) begin
      k = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    if (truncate) begin
      void'(body.pop_back());
    end
    push_item(ActRestart, 8'($urandom_range(255)));
    push_item(ActByte, FlagByte);
    // filler bytes never hit flag or escape codes
    repeat (pad) begin
      b = 8'($urandom_range(255));
      if (b == FlagByte || b == EscByte) begin
        b = b ^ 8'h01;
      end
      push_item(ActByte, b);
    end
    foreach (body[i]) begin
      b = body[i];
      // reserved codes must be escaped, others now and then as well
      if (b == FlagByte || b == EscByte ||
          ($urandom_range(7) == 0 && (b ^ EscXor) != FlagByte && (b ^ EscXor) != EscByte)) begin
        push_item(ActByte, EscByte);
        push_item(ActByte, b ^ EscXor);
      end else begin
        push_item(ActByte, b);
      end
    end
    push_item(ActByte, FlagByte);
    // up to two bytes after the close, which the block ignores
    repeat ($urandom_range(2)) push_item(ActByte, 8'($urandom_range(255)));
  endtask

  // mostly well-formed frames, some broken or corrupted, and raw noise in between
  task automatic run_phase(input int unsigned goal);
    int unsigned pick;
    int unsigned pad;
    int unsigned len;
    logic [7:0]  b;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        case ($urandom_range(31))
          0:       pad = 64;
          1:       pad = $urandom_range(70, 50);
          default: pad = 0;
        endcase
        len = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(10);
        send_frame(pad, len, $urandom_range(3) == 0, $urandom_range(15) == 0);
      end else begin
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(5))
            0, 1:    b = FlagByte;
            2:       b = EscByte;
            default: b = 8'($urandom_range(255));
          endcase
          push_item(($urandom_range(19) == 0) ? ActRestart : ActByte, b);
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bytes before the first flag are dropped, an early escape stays armed
    push_item(ActByte, 8'h41);
    push_item(ActByte, EscByte);
    push_item(ActByte, 8'h41);
    push_item(ActByte, FlagByte);
    // flag on an empty frame keeps it open
    push_item(ActByte, FlagByte);
    // early escape is used here, stored value 0x41
    push_item(ActByte, 8'h61);
    // one stored byte then a close: short frame, bad
    push_item(ActByte, FlagByte);
    // ignored after the frame end
    push_item(ActByte, 8'h00);
    push_item(ActByte, 8'hFF);
    push_item(ActByte, EscByte);
    push_item(ActByte, FlagByte);
    push_item(ActRestart, 8'hFF);
    // two zero bytes match the zero crc of an empty payload: good frame
    push_item(ActByte, FlagByte);
    push_item(ActByte, 8'h00);
    push_item(ActByte, 8'h00);
    push_item(ActByte, FlagByte);
    push_item(ActByte, 8'h13);
    push_item(ActRestart, 8'h00);
    // escaped flag and escape codes inside a frame
    push_item(ActByte, FlagByte);
    push_item(ActByte, EscByte);
    push_item(ActByte, 8'h5E);
    push_item(ActByte, EscByte);
    push_item(ActByte, 8'h5D);
    push_item(ActByte, 8'hFF);
    push_item(ActByte, FlagByte);

    // sender idles lightly, receiver stalls heavily
    run_phase(ItemsPerPhase);
    // the other way round
    send_idle_pct = 82;
    recv_idle_pct = 31;
    run_phase(2 * ItemsPerPhase);
    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(3 * ItemsPerPhase);
    in_valid <= 1'b0;

    // drain outstanding results, then keep the clock running to catch anything extra
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d transactions (%0d not ignored) under three flow-control mixes",
             sent, live_items);
    $display("%0d frames closed, %0d of them with a matching crc", frames, good_frames);
    if (errs == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hbd_pkg.sv
rtl/hdlc_byte_deframer_crc_check.sv
verif/hbd_checker.sv
verif/testbench.sv
